>>> design/hex_record_loader_core_assert.svh
// ----------------------------------------------------------------------------
// hex record loader assertion macros
// concurrent check wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LOADER_CORE_ASSERT_SVH
`define HEX_RECORD_LOADER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HRL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HRL_ASSERT_SAME(label, clk, rst, ante, cons)
`define HRL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/hrl_pkg.sv
// ----------------------------------------------------------------------------
// hex record loader package
// widths, parse phase codes, result kinds and the character to nibble map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrl_pkg;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 3;
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int PHASE_W = 4;
   localparam int NIB_W   = 4;

   localparam logic [PHASE_W-1:0] PH_START    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_COUNT    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_ADDR_HI  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_ADDR_LO  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_TYPE     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_DATA     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_CHECK    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_LINE_END = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;

   localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_END       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_START = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_TYPE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BAD_SUM   = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_EOF     = 8'hFF;
   localparam logic [CHAR_W-1:0] OFFSET_ALPHA = 8'd55;
   localparam logic [CHAR_W-1:0] OFFSET_DIGIT = 8'd48;

   localparam logic [DATA_W-1:0] TYPE_DATA = 8'd0;
   localparam logic [DATA_W-1:0] TYPE_EOF  = 8'd1;

   // full modulo-256 value, the low nibble of a byte adds all eight bits
   function automatic logic [CHAR_W-1:0] to_nibble(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      if (c > CHAR_NINE) begin
         t = c - OFFSET_ALPHA;
      end else begin
         t = c - OFFSET_DIGIT;
      end
      return t;
   endfunction

endpackage

>>> design/hrl_req_if.sv
// ----------------------------------------------------------------------------
// hex record loader character channel
// valid/ready channel carrying one image character per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrl_req_if;
   logic                       valid;
   logic                       ready;
   logic [hrl_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

>>> design/hrl_rsp_if.sv
// ----------------------------------------------------------------------------
// hex record loader result channel
// valid/ready channel carrying memory writes and load status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hrl_pkg::KIND_W-1:0] kind;
   logic [hrl_pkg::ADDR_W-1:0] write_address;
   logic [hrl_pkg::DATA_W-1:0] write_data;

   modport source (output valid, output kind, output write_address, output write_data,
                   input ready);
   modport sink   (input valid, input kind, input write_address, input write_data,
                   output ready);
endinterface

>>> design/hex_record_loader_core.sv
// ----------------------------------------------------------------------------
// hex record loader core
// parses a hex record image one character per item into memory writes and load status
// ----------------------------------------------------------------------------
//   channel   dir   payload                              handshake
//   req_ch    in    char_in[7:0]                         valid/ready
//   rsp_ch    out   kind[2:0] write_address[15:0]        valid/ready
//                   write_data[7:0]
//
// one character per cycle sustained while rsp_ch is not stalled
// the input register feeds the parse logic, the result register holds its output
// synchronous reset returns the parser to waiting for a colon
// a stalled result holds the input register, which then back-pressures req_ch
// after a terminal status every further character is absorbed until reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hex_record_loader_core_assert.svh"

module hex_record_loader_core (
   input  logic       clock,
   input  logic       reset,
   hrl_req_if.sink    req_ch,
   hrl_rsp_if.source  rsp_ch
);

   logic                          in_valid_ff, in_valid_in;
   logic [hrl_pkg::CHAR_W-1:0]    in_char_ff, in_char_in;

   logic [hrl_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                          second_ff, second_in;
   logic [hrl_pkg::NIB_W-1:0]     high_nib_ff, high_nib_in;
   logic [hrl_pkg::DATA_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [hrl_pkg::ADDR_W-1:0]    load_addr_ff, load_addr_in;
   logic [hrl_pkg::DATA_W-1:0]    sum_ff, sum_in;

   logic                          out_valid_ff, out_valid_in;
   logic [hrl_pkg::KIND_W-1:0]    out_kind_ff, out_kind_in;
   logic [hrl_pkg::ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [hrl_pkg::DATA_W-1:0]    out_data_ff, out_data_in;

   logic                          advance;
   logic                          emit;
   logic                          byte_phase;
   logic [hrl_pkg::CHAR_W-1:0]    nib;
   logic [hrl_pkg::DATA_W-1:0]    byte_val;
   logic [hrl_pkg::DATA_W-1:0]    sum_next;
   logic [hrl_pkg::DATA_W-1:0]    left_dec;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;

   assign nib        = hrl_pkg::to_nibble(in_char_ff);
   assign byte_val   = {high_nib_ff, 4'h0} + nib;
   assign sum_next   = sum_ff + byte_val;
   assign left_dec   = bytes_left_ff - 8'd1;
   assign byte_phase = (phase_ff >= hrl_pkg::PH_COUNT) && (phase_ff <= hrl_pkg::PH_CHECK);

   // input register
   always_comb begin
      in_char_in = in_char_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_ch.char_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // parse step
   always_comb begin
      phase_in      = phase_ff;
      second_in     = second_ff;
      high_nib_in   = high_nib_ff;
      bytes_left_in = bytes_left_ff;
      load_addr_in  = load_addr_ff;
      sum_in        = sum_ff;
      emit          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_addr_in   = out_addr_ff;
      out_data_in   = out_data_ff;

      if (advance) begin
         out_kind_in = hrl_pkg::KIND_WRITE;
         out_addr_in = '0;
         out_data_in = '0;
         priority if (phase_ff == hrl_pkg::PH_START) begin
            if (in_char_ff == hrl_pkg::CHAR_EOF) begin
               phase_in = hrl_pkg::PH_DONE;
            end else if (in_char_ff != hrl_pkg::CHAR_COLON) begin
               phase_in    = hrl_pkg::PH_DONE;
               emit        = 1'b1;
               out_kind_in = hrl_pkg::KIND_BAD_START;
            end else begin
               sum_in    = '0;
               second_in = 1'b0;
               phase_in  = hrl_pkg::PH_COUNT;
            end
         end else if (phase_ff == hrl_pkg::PH_LINE_END) begin
            if (sum_ff != '0) begin
               phase_in    = hrl_pkg::PH_DONE;
               emit        = 1'b1;
               out_kind_in = hrl_pkg::KIND_BAD_SUM;
            end else begin
               phase_in = hrl_pkg::PH_START;
            end
         end else if (byte_phase && !second_ff) begin
            high_nib_in = nib[hrl_pkg::NIB_W-1:0];
            second_in   = 1'b1;
         end else if (byte_phase) begin
            second_in = 1'b0;
            sum_in    = sum_next;
            unique case (phase_ff)
               hrl_pkg::PH_COUNT: begin
                  if (byte_val == '0) begin
                     phase_in    = hrl_pkg::PH_DONE;
                     emit        = 1'b1;
                     out_kind_in = hrl_pkg::KIND_END;
                  end else begin
                     bytes_left_in = byte_val;
                     phase_in      = hrl_pkg::PH_ADDR_HI;
                  end
               end
               hrl_pkg::PH_ADDR_HI: begin
                  load_addr_in = {byte_val, 8'd0};
                  phase_in     = hrl_pkg::PH_ADDR_LO;
               end
               hrl_pkg::PH_ADDR_LO: begin
                  load_addr_in = {load_addr_ff[15:8], byte_val};
                  phase_in     = hrl_pkg::PH_TYPE;
               end
               hrl_pkg::PH_TYPE: begin
                  if (byte_val == hrl_pkg::TYPE_EOF) begin
                     phase_in    = hrl_pkg::PH_DONE;
                     emit        = 1'b1;
                     out_kind_in = hrl_pkg::KIND_END;
                  end else if (byte_val != hrl_pkg::TYPE_DATA) begin
                     phase_in    = hrl_pkg::PH_DONE;
                     emit        = 1'b1;
                     out_kind_in = hrl_pkg::KIND_BAD_TYPE;
                  end else begin
                     phase_in = hrl_pkg::PH_DATA;
                  end
               end
               hrl_pkg::PH_DATA: begin
                  emit          = 1'b1;
                  out_kind_in   = hrl_pkg::KIND_WRITE;
                  out_addr_in   = load_addr_ff;
                  out_data_in   = byte_val;
                  load_addr_in  = load_addr_ff + 16'd1;
                  bytes_left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = hrl_pkg::PH_CHECK;
                  end
               end
               default: begin
                  phase_in = hrl_pkg::PH_LINE_END;
               end
            endcase
         end else begin
            // done and unused codes absorb
            phase_in = phase_ff;
         end
      end
   end

   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= hrl_pkg::PH_START;
         second_ff     <= 1'b0;
         high_nib_ff   <= '0;
         bytes_left_ff <= '0;
         load_addr_ff  <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         phase_ff      <= phase_in;
         second_ff     <= second_in;
         high_nib_ff   <= high_nib_in;
         bytes_left_ff <= bytes_left_in;
         load_addr_ff  <= load_addr_in;
         sum_ff        <= sum_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      if (advance && emit) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.kind          = out_kind_ff;
   assign rsp_ch.write_address = out_addr_ff;
   assign rsp_ch.write_data    = out_data_ff;

   `HRL_ASSERT_NEXT(a_done_silent, clock, reset,
                    (phase_ff == hrl_pkg::PH_DONE) && !out_valid_ff, !out_valid_ff)
   `HRL_ASSERT_SAME(a_status_is_final, clock, reset,
                    out_valid_ff && (out_kind_ff != hrl_pkg::KIND_WRITE),
                    phase_ff == hrl_pkg::PH_DONE)
   `HRL_ASSERT_NEXT(a_held_char, clock, reset,
                    in_valid_ff && !advance, in_valid_ff && $stable(in_char_ff))

endmodule

>>> verif/tb_hex_record_loader_core.sv
// ----------------------------------------------------------------------------
// hex record loader core testbench
// streams hex record images into the loader one character per item and
// checks every memory write and status against a cycle-free parser model;
// records are mostly well formed with random, partly non-canonical character
// encodings, and each run ends on one terminal condition picked at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hex_record_loader_core;

   typedef struct packed {
      logic [hrl_pkg::KIND_W-1:0] kind;
      logic [hrl_pkg::ADDR_W-1:0] address;
      logic [hrl_pkg::DATA_W-1:0] data;
   } load_result_type;

   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_CR   = 8'h0D;
   localparam int                         LONG_HOLD = 80;
   localparam int                         RANDOM_CHARS = 1100;

   logic clock;
   logic reset;

   hrl_req_if req_ch ();
   hrl_rsp_if rsp_ch ();

   hex_record_loader_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // parser model state
   logic [hrl_pkg::PHASE_W-1:0] parse_phase;
   logic                        low_char_due;
   logic [7:0]                  high_part;
   logic [7:0]                  data_left;
   logic [hrl_pkg::ADDR_W-1:0]  next_address;
   logic [7:0]                  record_sum;

   load_result_type    pending_writes[$];
   logic [7:0]         record_data[$];
   int                 errors;
   int                 chars_sent;
   bit                 idle_off;
   bit                 noise_on;
   bit                 hold_request;
   int                 hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_hex_record_loader_core: FAIL");
      $finish;
   end

   function automatic logic [7:0] char_value(input logic [7:0] c);
      if (c > hrl_pkg::CHAR_NINE) begin
         return c - hrl_pkg::OFFSET_ALPHA;
      end
      return c - hrl_pkg::OFFSET_DIGIT;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) begin
         return hrl_pkg::OFFSET_DIGIT + {4'h0, n};
      end
      return hrl_pkg::OFFSET_ALPHA + {4'h0, n};
   endfunction

   function automatic logic [7:0] pick_line_end();
      case ($urandom_range(0, 3))
         0, 1: return CHAR_LF;
         2: return CHAR_CR;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic add_expected(input logic [hrl_pkg::KIND_W-1:0] kind,
                               input logic [hrl_pkg::ADDR_W-1:0] address,
                               input logic [hrl_pkg::DATA_W-1:0] data);
      load_result_type r;
      r.kind    = kind;
      r.address = address;
      r.data    = data;
      pending_writes.push_back(r);
   endtask

   task automatic stop_loading(input logic [hrl_pkg::KIND_W-1:0] kind);
      parse_phase = hrl_pkg::PH_DONE;
      add_expected(kind, '0, '0);
   endtask

   task automatic parse_char(input logic [7:0] c);
      logic [7:0] cv;
      logic [7:0] b;
      cv = char_value(c);
      if (parse_phase == hrl_pkg::PH_START) begin
         if (c == hrl_pkg::CHAR_EOF) begin
            parse_phase = hrl_pkg::PH_DONE;
         end else if (c != hrl_pkg::CHAR_COLON) begin
            stop_loading(hrl_pkg::KIND_BAD_START);
         end else begin
            record_sum   = '0;
            low_char_due = 1'b0;
            parse_phase  = hrl_pkg::PH_COUNT;
         end
      end else if (parse_phase == hrl_pkg::PH_LINE_END) begin
         if (record_sum != 8'h00) begin
            stop_loading(hrl_pkg::KIND_BAD_SUM);
         end else begin
            parse_phase = hrl_pkg::PH_START;
         end
      end else if (parse_phase >= hrl_pkg::PH_COUNT && parse_phase <= hrl_pkg::PH_CHECK) begin
         if (!low_char_due) begin
            high_part    = {cv[3:0], 4'h0};
            low_char_due = 1'b1;
         end else begin
            low_char_due = 1'b0;
            b            = high_part + cv;
            record_sum   = record_sum + b;
            case (parse_phase)
               hrl_pkg::PH_COUNT: begin
                  if (b == 8'h00) begin
                     stop_loading(hrl_pkg::KIND_END);
                  end else begin
                     data_left   = b;
                     parse_phase = hrl_pkg::PH_ADDR_HI;
                  end
               end
               hrl_pkg::PH_ADDR_HI: begin
                  next_address = {b, 8'h00};
                  parse_phase  = hrl_pkg::PH_ADDR_LO;
               end
               hrl_pkg::PH_ADDR_LO: begin
                  next_address[7:0] = b;
                  parse_phase       = hrl_pkg::PH_TYPE;
               end
               hrl_pkg::PH_TYPE: begin
                  if (b == hrl_pkg::TYPE_EOF) begin
                     stop_loading(hrl_pkg::KIND_END);
                  end else if (b != hrl_pkg::TYPE_DATA) begin
                     stop_loading(hrl_pkg::KIND_BAD_TYPE);
                  end else begin
                     parse_phase = hrl_pkg::PH_DATA;
                  end
               end
               hrl_pkg::PH_DATA: begin
                  add_expected(hrl_pkg::KIND_WRITE, next_address, b);
                  next_address = next_address + 16'd1;
                  data_left    = data_left - 8'd1;
                  if (data_left == 8'h00) begin
                     parse_phase = hrl_pkg::PH_CHECK;
                  end
               end
               default: begin
                  parse_phase = hrl_pkg::PH_LINE_END;
               end
            endcase
         end
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      int gap;
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.char_in = c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_char(c);
      chars_sent++;
   endtask

   // two characters per byte, sometimes with characters outside the hex digits
   task automatic send_byte(input logic [7:0] value);
      logic [7:0] hi_c;
      logic [7:0] lo_c;
      logic [7:0] cv;
      logic [7:0] need;
      bit         found;
      hi_c  = hex_digit(value[7:4]);
      lo_c  = hex_digit(value[3:0]);
      found = 1'b0;
      if (noise_on && $urandom_range(0, 3) == 0) begin
         while (!found) begin
            hi_c = 8'($urandom_range(0, 255));
            cv   = char_value(hi_c);
            need = value - {cv[3:0], 4'h0};
            lo_c = need + hrl_pkg::OFFSET_ALPHA;
            if (lo_c > hrl_pkg::CHAR_NINE) begin
               found = 1'b1;
            end else begin
               lo_c  = need + hrl_pkg::OFFSET_DIGIT;
               found = (lo_c <= hrl_pkg::CHAR_NINE);
            end
         end
      end
      send_char(hi_c);
      send_char(lo_c);
   endtask

   // count comes from the size of record_data, which is emptied afterwards
   task automatic send_record(input logic [hrl_pkg::ADDR_W-1:0] address,
                              input logic [7:0] rtype,
                              input logic [7:0] sum_error, input logic [7:0] line_end);
      logic [7:0] cnt;
      logic [7:0] sum;
      cnt = 8'(record_data.size());
      sum = cnt + address[15:8] + address[7:0] + rtype;
      send_char(hrl_pkg::CHAR_COLON);
      send_byte(cnt);
      send_byte(address[15:8]);
      send_byte(address[7:0]);
      send_byte(rtype);
      foreach (record_data[i]) begin
         send_byte(record_data[i]);
         sum = sum + record_data[i];
      end
      send_byte(8'h00 - sum + sum_error);
      send_char(line_end);
      record_data.delete();
   endtask

   task automatic fill_data(input int n);
      repeat (n) record_data.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      noise_on = 1'b0;
      record_data = '{8'h00, 8'hFF};
      send_record(16'hFFFF, hrl_pkg::TYPE_DATA, 8'h00, hrl_pkg::CHAR_EOF);
      noise_on = 1'b1;
      record_data = '{8'h5A};
      send_record(16'h0000, hrl_pkg::TYPE_DATA, 8'h00, CHAR_CR);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_request = 1'b1;
      idle_off     = 1'b1;
      fill_data(24);
      send_record(16'($urandom_range(0, 16'hFFFF)), hrl_pkg::TYPE_DATA, 8'h00, CHAR_LF);
      idle_off     = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_records();
      int                         start;
      logic [hrl_pkg::ADDR_W-1:0] address;
      start = chars_sent;
      while (chars_sent - start < RANDOM_CHARS) begin
         if (chars_sent - start > RANDOM_CHARS - 200) begin
            idle_off = 1'b1;
         end
         if ($urandom_range(0, 49) == 0) begin
            fill_data($urandom_range(100, 255));
         end else begin
            fill_data($urandom_range(1, 16));
         end
         if ($urandom_range(0, 7) == 0) begin
            address = 16'hFFFF - 16'($urandom_range(0, 8));
         end else begin
            address = 16'($urandom_range(0, 16'hFFFF));
         end
         send_record(address, hrl_pkg::TYPE_DATA, 8'h00, pick_line_end());
      end
   endtask

   // one terminal condition per run, then characters the loader must absorb
   task automatic test_terminal();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: send_char(hrl_pkg::CHAR_EOF);
         1: begin
            c = 8'($urandom_range(0, 253));
            if (c == hrl_pkg::CHAR_COLON) begin
               c = 8'hFE;
            end
            send_char(c);
         end
         2: send_record(16'($urandom_range(0, 16'hFFFF)), hrl_pkg::TYPE_DATA, 8'h00, CHAR_LF);
         3: begin
            fill_data($urandom_range(0, 4));
            send_record(16'($urandom_range(0, 16'hFFFF)), hrl_pkg::TYPE_EOF, 8'h00, CHAR_LF);
         end
         4: begin
            fill_data($urandom_range(1, 4));
            send_record(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(2, 255)), 8'h00,
                        CHAR_LF);
         end
         default: begin
            fill_data($urandom_range(1, 8));
            send_record(16'($urandom_range(0, 16'hFFFF)), hrl_pkg::TYPE_DATA,
                        8'($urandom_range(1, 255)), pick_line_end());
         end
      endcase
      repeat (30) send_char(8'($urandom_range(0, 255)));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // result receiver with random stalls and one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b1;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_ch.ready = 1'b0;
         end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            hold_left    = $urandom_range(1, 19) - 1;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      load_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_writes.size() == 0) begin
            report_error($sformatf("unexpected item kind %0d address %h data %h",
                                   rsp_ch.kind, rsp_ch.write_address, rsp_ch.write_data));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_ch.kind !== want.kind) begin
               report_error($sformatf("kind %0d, expected %0d", rsp_ch.kind, want.kind));
            end
            if (rsp_ch.write_address !== want.address) begin
               report_error($sformatf("write_address %h, expected %h",
                                      rsp_ch.write_address, want.address));
            end
            if (rsp_ch.write_data !== want.data) begin
               report_error($sformatf("write_data %h, expected %h",
                                      rsp_ch.write_data, want.data));
            end
         end
      end
   end

   initial begin
      int guard;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.char_in = '0;
      errors         = 0;
      chars_sent     = 0;
      idle_off       = 1'b0;
      noise_on       = 1'b0;
      hold_request   = 1'b0;
      parse_phase    = hrl_pkg::PH_START;
      low_char_due   = 1'b0;
      high_part      = '0;
      data_left      = '0;
      next_address   = '0;
      record_sum     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random_records();
      test_terminal();

      guard = 0;
      while (pending_writes.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      foreach (pending_writes[i]) begin
         report_error($sformatf("missing item kind %0d address %h data %h",
                                pending_writes[i].kind, pending_writes[i].address,
                                pending_writes[i].data));
      end
      if (errors == 0) begin
         $display("tb_hex_record_loader_core: PASS");
      end else begin
         $display("tb_hex_record_loader_core: FAIL");
      end
      $finish;
   end

endmodule
